// ===== design/cdq_pkg.sv =====
// Shared types, field widths and request/status codes for the connection deque.
// Used by cdq_ctrl and the top level; depends on nothing else.
package cdq_pkg;

   // Field widths of the request and response beats.
   localparam int KIND_W   = 2;
   localparam int CONN_W   = 16;
   localparam int STAMP_W  = 32;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = CONN_W + STAMP_W;

   // Default number of queue slots.
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_PUSH     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP_HEAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP_TAIL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [STATUS_W-1:0] status_type;

   // One stored queue entry.
   typedef struct packed {
      logic [CONN_W-1:0]  conn;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Response beat handed from the sequencer to the output register stage.
   typedef struct packed {
      logic                strobe;
      logic                entry_valid;
      logic [CONN_W-1:0]   removed_connection;
      logic [STAMP_W-1:0]  removed_stamp;
      count_type           entry_count;
      status_type          status;
   } rsp_beat_type;

endpackage

// ===== design/cdq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Self-contained; no package dependencies.
module cdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cdq_ctrl.sv =====
// Sequencer of the connection deque: head pointer, occupancy and the read,
// shift and write-back steps on the entry RAM. Depends on cdq_pkg.
module cdq_ctrl #(
   parameter int QUEUE_DEPTH = cdq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cdq_pkg::KIND_W-1:0]      req_kind,
   input  logic [cdq_pkg::CONN_W-1:0]      req_connection_id,
   input  logic [cdq_pkg::STAMP_W-1:0]     req_arrival_stamp,
   input  logic [cdq_pkg::POS_W-1:0]       req_position,
   output logic                            mem_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]  mem_wr_addr,
   output cdq_pkg::entry_type              mem_wr_data,
   output logic                            mem_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]  mem_rd_addr,
   input  cdq_pkg::entry_type              mem_rd_data,
   output cdq_pkg::rsp_beat_type           rsp_beat
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW = (OW > cdq_pkg::POS_W) ? OW : cdq_pkg::POS_W;

   typedef logic [PW-1:0] ptr_type;
   typedef logic [OW-1:0] occ_type;
   typedef logic [CW-1:0] cmp_type;

   localparam logic [PW:0]   DEPTH_WIDE = QUEUE_DEPTH[PW:0];
   localparam logic [OW-1:0] DEPTH_OCC  = QUEUE_DEPTH[OW-1:0];

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SHIFT = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   ptr_type                     head_ff, head_in;
   occ_type                     occ_ff, occ_in;
   logic [cdq_pkg::KIND_W-1:0]  kind_ff, kind_in;
   ptr_type                     k_ff, k_in;
   cdq_pkg::entry_type          removed_ff, removed_in;

   logic                        accept;
   occ_type                     occ_last;
   occ_type                     k_wide;
   ptr_type                     offset;
   logic                        finish;
   cdq_pkg::entry_type          finish_entry;

   // Physical slot of a logical offset from the head, wrapped once.
   function automatic ptr_type slot_of(input ptr_type head, input ptr_type off);
      logic [PW:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= DEPTH_WIDE) begin
         sum = sum - DEPTH_WIDE;
      end
      return sum[PW-1:0];
   endfunction

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign occ_last = occ_ff - occ_type'(1);
   assign k_wide   = occ_type'(k_ff);

   // Next-state logic: decode in idle, then fetch the removed entry and, for a
   // remove, shift later entries one slot toward the head, one entry per cycle.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      kind_in      = kind_ff;
      k_in         = k_ff;
      removed_in   = removed_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_of(head_ff, k_ff);
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      rsp_beat     = '0;
      finish       = 1'b0;
      finish_entry = mem_rd_data;
      offset       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == cdq_pkg::KIND_PUSH) begin
                  rsp_beat.strobe = 1'b1;
                  if (occ_ff == DEPTH_OCC) begin
                     rsp_beat.status = cdq_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en        = 1'b1;
                     mem_wr_addr      = slot_of(head_ff, ptr_type'(occ_ff));
                     mem_wr_data.conn  = req_connection_id;
                     mem_wr_data.stamp = req_arrival_stamp;
                     occ_in           = occ_ff + occ_type'(1);
                     rsp_beat.status  = cdq_pkg::STATUS_OK;
                  end
                  rsp_beat.entry_count = cdq_pkg::count_type'(occ_in);
               end else if (occ_ff == '0) begin
                  rsp_beat.strobe      = 1'b1;
                  rsp_beat.status      = cdq_pkg::STATUS_EMPTY;
                  rsp_beat.entry_count = cdq_pkg::count_type'(occ_ff);
               end else if (req_kind == cdq_pkg::KIND_REMOVE &&
                            cmp_type'(req_position) >= cmp_type'(occ_ff)) begin
                  rsp_beat.strobe      = 1'b1;
                  rsp_beat.status      = cdq_pkg::STATUS_RANGE;
                  rsp_beat.entry_count = cdq_pkg::count_type'(occ_ff);
               end else begin
                  priority if (req_kind == cdq_pkg::KIND_POP_HEAD) begin
                     offset = '0;
                  end else if (req_kind == cdq_pkg::KIND_POP_TAIL) begin
                     offset = ptr_type'(occ_last);
                  end else begin
                     offset = ptr_type'(req_position);
                  end
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_of(head_ff, offset);
                  kind_in     = req_kind;
                  k_in        = offset;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // Read data now holds the entry being removed.
            if (kind_ff == cdq_pkg::KIND_REMOVE && k_wide != occ_last) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_of(head_ff, k_ff + ptr_type'(1));
               removed_in  = mem_rd_data;
               state_in    = ST_SHIFT;
            end else begin
               finish       = 1'b1;
               finish_entry = mem_rd_data;
            end
         end
         ST_SHIFT: begin
            // Read data holds the entry after slot k; move it into slot k.
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_of(head_ff, k_ff);
            mem_wr_data = mem_rd_data;
            k_in        = k_ff + ptr_type'(1);
            if (k_wide + occ_type'(1) != occ_last) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_of(head_ff, k_ff + ptr_type'(2));
            end else begin
               finish       = 1'b1;
               finish_entry = removed_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Completion of a removal: report the entry and shrink the queue.
      if (finish) begin
         occ_in                      = occ_ff - occ_type'(1);
         state_in                    = ST_IDLE;
         if (kind_ff == cdq_pkg::KIND_POP_HEAD) begin
            head_in = slot_of(head_ff, ptr_type'(1));
         end
         rsp_beat.strobe             = 1'b1;
         rsp_beat.entry_valid        = 1'b1;
         rsp_beat.removed_connection = finish_entry.conn;
         rsp_beat.removed_stamp      = finish_entry.stamp;
         rsp_beat.entry_count        = cdq_pkg::count_type'(occ_in);
         rsp_beat.status             = cdq_pkg::STATUS_OK;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      k_ff       <= k_in;
      removed_ff <= removed_in;
   end

endmodule

// ===== design/connection_deque_with_index_removal.sv =====
// Top level of the connection deque: sequencer, entry RAM and response register.
// Depends on cdq_pkg, cdq_ram and cdq_ctrl.
//
// Usage: a request beat is taken when start is high and busy is low. It carries
// req_kind (push at tail, pop head, pop tail, remove at position), the
// connection number and arrival stamp to push, and the position to remove.
// Every request gives exactly one response beat, shown on the rsp_ ports for a
// single cycle while rsp_strobe is high; the receiver cannot stall it.
// A push, and any refused request, holds busy low: the response appears in
// the cycle after acceptance and the next request may be taken at once.
// Pop head and pop tail keep busy high for the RAM read of the entry they
// return. Remove at position p reads that entry, then moves each later
// entry one slot toward the head over the single RAM write port before
// it responds. The response strobes in the cycle busy drops.
// Reset empties the queue and clears the head pointer; stored entries are
// left as they are and are never read before being pushed again.
module connection_deque_with_index_removal #(
   parameter int QUEUE_DEPTH = cdq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cdq_pkg::KIND_W-1:0]    req_kind,
   input  logic [cdq_pkg::CONN_W-1:0]    req_connection_id,
   input  logic [cdq_pkg::STAMP_W-1:0]   req_arrival_stamp,
   input  logic [cdq_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_strobe,
   output logic                          rsp_entry_valid,
   output logic [cdq_pkg::CONN_W-1:0]    rsp_removed_connection,
   output logic [cdq_pkg::STAMP_W-1:0]   rsp_removed_stamp,
   output logic [cdq_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [cdq_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic                   mem_wr_en;
   logic [PW-1:0]          mem_wr_addr;
   cdq_pkg::entry_type     mem_wr_data;
   logic                   mem_rd_en;
   logic [PW-1:0]          mem_rd_addr;
   cdq_pkg::entry_type     mem_rd_data;
   cdq_pkg::rsp_beat_type  rsp_beat;

   logic                   strobe_ff;
   cdq_pkg::rsp_beat_type  beat_ff;

   // Sequencer.
   cdq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_connection_id (req_connection_id),
      .req_arrival_stamp (req_arrival_stamp),
      .req_position      (req_position),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .rsp_beat          (rsp_beat)
   );

   // Entry storage: connection number and stamp per slot.
   cdq_ram #(
      .WIDTH (cdq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response register: the strobe is reset, the payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rsp_beat.strobe;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat.strobe) begin
         beat_ff <= rsp_beat;
      end
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_entry_valid        = beat_ff.entry_valid;
   assign rsp_removed_connection = beat_ff.removed_connection;
   assign rsp_removed_stamp      = beat_ff.removed_stamp;
   assign rsp_entry_count        = beat_ff.entry_count;
   assign rsp_status             = beat_ff.status;

   // A multi-cycle request always ends with its response beat.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response beat");

   // Only a successful request returns an entry.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_valid) |-> (rsp_status == cdq_pkg::STATUS_OK))
      else $error("entry returned with a refusal status");

   // A refused push reports a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == cdq_pkg::STATUS_FULL) |->
         (rsp_entry_count == cdq_pkg::count_type'(QUEUE_DEPTH) && !rsp_entry_valid))
      else $error("full refusal with a queue that is not full");

endmodule
